>>> design/ptnp_pkg.sv
package ptnp_pkg;

  // Miller-Rabin bases, exact for every value below 2^32
  localparam int unsigned NumBases = 3;
  localparam int unsigned BaseW    = 8;
  localparam logic [BaseW-1:0] MR_BASES [NumBases] = '{8'd2, 8'd7, 8'd61};

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_CHECK   = 13'b0000000000010,
    S_DECOMP  = 13'b0000000000100,
    S_BASE    = 13'b0000000001000,
    S_SQ      = 13'b0000000010000,
    S_SQ_W    = 13'b0000000100000,
    S_ML      = 13'b0000001000000,
    S_ML_W    = 13'b0000010000000,
    S_EVAL    = 13'b0000100000000,
    S_LOOP    = 13'b0001000000000,
    S_LOOP_W  = 13'b0010000000000,
    S_VERDICT = 13'b0100000000000,
    S_FIN     = 13'b1000000000000
  } state_e;

  // handshake between sequencer and modular multiplier
  typedef struct packed {
    logic start;
    logic use_base;
  } mm_req_t;

endpackage

>>> design/ptnp_modmul.sv
// Bit-serial modular multiplier: res = a * b mod n, a and b below n.
// Walks b from its MSB; each bit takes a doubling step and then an add step.
module ptnp_modmul #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] n_i,
  output logic         done_o,
  output logic [W-1:0] res_o
);

  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  acc_q, acc_d, a_q, a_d, b_q, b_d, n_q, n_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ph_q, ph_d, run_q, run_d, done_q, done_d;
  logic [W:0]    sum, red;

  always_comb begin
    if (!ph_q) begin
      sum = {acc_q, 1'b0};
    end else begin
      sum = {1'b0, acc_q} + (b_q[W-1] ? {1'b0, a_q} : '0);
    end
    red = (sum >= {1'b0, n_q}) ? (sum - {1'b0, n_q}) : sum;
  end

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    n_d    = n_q;
    cnt_d  = cnt_q;
    ph_d   = ph_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = '0;
      a_d   = a_i;
      b_d   = b_i;
      n_d   = n_i;
      cnt_d = CW'(W - 1);
      ph_d  = 1'b0;
      run_d = 1'b1;
    end else if (run_q) begin
      acc_d = red[W-1:0];
      ph_d  = ~ph_q;
      if (ph_q) begin
        b_d = {b_q[W-2:0], 1'b0};
        if (cnt_q == '0) begin
          run_d  = 1'b0;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
    n_q   <= n_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

>>> design/prime_test_and_next_prime.sv
// Primality test / next-prime search, deterministic Miller-Rabin (bases 2, 7, 61).
// Work: each modular multiply runs in the bit-serial multiplier; a test costs up to
//   2*W multiplies per base for the power plus up to s-1 squarings per base, and a search
//   repeats the test for each odd candidate tried. Trivial values skip the Miller-Rabin steps.
// Throughput: one item at a time; the next is taken once the result sits in the output register.
// Reset: rst_ni asynchronous active low, clears the sequencer, the multiplier control and output valid only.
module prime_test_and_next_prime #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   operation_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   is_prime_o,
  output logic [VALUE_WIDTH-1:0] prime_found_o,
  output logic                   overflow_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(W);

  ptnp_pkg::state_e state_q, state_d;

  // candidate has one spare bit so the search can step past 2^W - 1
  logic [W:0]    cand_q, cand_d;
  logic          op_q, op_d;
  logic [W-1:0]  d_q, d_d, x_q, x_d, a_q, a_d;
  logic [CW-1:0] s_q, s_d, k_q, k_d, e_q, e_d;
  logic [1:0]    bidx_q, bidx_d;
  logic          verdict_q, verdict_d;
  logic          fin_prime_q, fin_prime_d, fin_ovf_q, fin_ovf_d;

  logic          out_valid_q, out_valid_d;
  logic          is_prime_q, is_prime_d, ovf_q, ovf_d;
  logic [W-1:0]  prime_q, prime_d;

  logic [W-1:0]  n, nm1, base_w, mm_res;
  logic          mm_done;
  ptnp_pkg::mm_req_t mm_req;

  assign n   = cand_q[W-1:0];
  assign nm1 = n - 1'b1;

  always_comb begin
    case (bidx_q)
      2'd0:    base_w = {{(W-ptnp_pkg::BaseW){1'b0}}, ptnp_pkg::MR_BASES[0]};
      2'd1:    base_w = {{(W-ptnp_pkg::BaseW){1'b0}}, ptnp_pkg::MR_BASES[1]};
      default: base_w = {{(W-ptnp_pkg::BaseW){1'b0}}, ptnp_pkg::MR_BASES[2]};
    endcase
  end

  assign mm_req.start    = (state_q == ptnp_pkg::S_SQ) || (state_q == ptnp_pkg::S_ML) ||
                           ((state_q == ptnp_pkg::S_LOOP) && (k_q < s_q));
  assign mm_req.use_base = (state_q == ptnp_pkg::S_ML);

  ptnp_modmul #(.W(W)) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_req.start),
    .a_i     (x_q),
    .b_i     (mm_req.use_base ? a_q : x_q),
    .n_i     (n),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  assign in_ready_o = (state_q == ptnp_pkg::S_IDLE);

  always_comb begin
    state_d     = state_q;
    cand_d      = cand_q;
    op_d        = op_q;
    d_d         = d_q;
    x_d         = x_q;
    a_d         = a_q;
    s_d         = s_q;
    k_d         = k_q;
    e_d         = e_q;
    bidx_d      = bidx_q;
    verdict_d   = verdict_q;
    fin_prime_d = fin_prime_q;
    fin_ovf_d   = fin_ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    is_prime_d  = is_prime_q;
    prime_d     = prime_q;
    ovf_d       = ovf_q;

    case (state_q)
      ptnp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d    = operation_i;
          // search starts from the odd value at or above the input
          cand_d  = {1'b0, value_i | {{(W-1){1'b0}}, operation_i}};
          state_d = ptnp_pkg::S_CHECK;
        end
      end
      ptnp_pkg::S_CHECK: begin
        if (cand_q[W]) begin
          fin_prime_d = 1'b0;
          fin_ovf_d   = 1'b1;
          state_d     = ptnp_pkg::S_FIN;
        end else if (n < W'(2)) begin
          verdict_d = 1'b0;
          state_d   = ptnp_pkg::S_VERDICT;
        end else if (n == W'(2)) begin
          verdict_d = 1'b1;
          state_d   = ptnp_pkg::S_VERDICT;
        end else if (!n[0]) begin
          verdict_d = 1'b0;
          state_d   = ptnp_pkg::S_VERDICT;
        end else begin
          d_d     = nm1;
          s_d     = '0;
          state_d = ptnp_pkg::S_DECOMP;
        end
      end
      ptnp_pkg::S_DECOMP: begin
        // strip factors of two from n-1, one per cycle
        if (!d_q[0]) begin
          d_d = {1'b0, d_q[W-1:1]};
          s_d = s_q + 1'b1;
        end else begin
          bidx_d  = '0;
          state_d = ptnp_pkg::S_BASE;
        end
      end
      ptnp_pkg::S_BASE: begin
        if (bidx_q == 2'(ptnp_pkg::NumBases) || base_w >= n) begin
          verdict_d = 1'b1;
          state_d   = ptnp_pkg::S_VERDICT;
        end else begin
          a_d     = base_w;
          x_d     = {{(W-1){1'b0}}, 1'b1};
          e_d     = CW'(W - 1);
          state_d = ptnp_pkg::S_SQ;
        end
      end
      ptnp_pkg::S_SQ: begin
        state_d = ptnp_pkg::S_SQ_W;
      end
      ptnp_pkg::S_SQ_W: begin
        if (mm_done) begin
          x_d = mm_res;
          if (d_q[e_q]) begin
            state_d = ptnp_pkg::S_ML;
          end else if (e_q == '0) begin
            state_d = ptnp_pkg::S_EVAL;
          end else begin
            e_d     = e_q - 1'b1;
            state_d = ptnp_pkg::S_SQ;
          end
        end
      end
      ptnp_pkg::S_ML: begin
        state_d = ptnp_pkg::S_ML_W;
      end
      ptnp_pkg::S_ML_W: begin
        if (mm_done) begin
          x_d = mm_res;
          if (e_q == '0) begin
            state_d = ptnp_pkg::S_EVAL;
          end else begin
            e_d     = e_q - 1'b1;
            state_d = ptnp_pkg::S_SQ;
          end
        end
      end
      ptnp_pkg::S_EVAL: begin
        if (x_q == {{(W-1){1'b0}}, 1'b1} || x_q == nm1) begin
          bidx_d  = bidx_q + 1'b1;
          state_d = ptnp_pkg::S_BASE;
        end else begin
          k_d     = {{(CW-1){1'b0}}, 1'b1};
          state_d = ptnp_pkg::S_LOOP;
        end
      end
      ptnp_pkg::S_LOOP: begin
        if (k_q < s_q) begin
          state_d = ptnp_pkg::S_LOOP_W;
        end else begin
          verdict_d = 1'b0;
          state_d   = ptnp_pkg::S_VERDICT;
        end
      end
      ptnp_pkg::S_LOOP_W: begin
        if (mm_done) begin
          x_d = mm_res;
          if (mm_res == nm1) begin
            bidx_d  = bidx_q + 1'b1;
            state_d = ptnp_pkg::S_BASE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ptnp_pkg::S_LOOP;
          end
        end
      end
      ptnp_pkg::S_VERDICT: begin
        if (!op_q || verdict_q) begin
          fin_prime_d = verdict_q;
          fin_ovf_d   = 1'b0;
          state_d     = ptnp_pkg::S_FIN;
        end else begin
          cand_d  = cand_q + (W+1)'(2);
          state_d = ptnp_pkg::S_CHECK;
        end
      end
      ptnp_pkg::S_FIN: begin
        // hand the item over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          is_prime_d  = fin_prime_q;
          ovf_d       = fin_ovf_q;
          prime_d     = fin_ovf_q ? '0 : n;
          state_d     = ptnp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ptnp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptnp_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q      <= cand_d;
    op_q        <= op_d;
    d_q         <= d_d;
    x_q         <= x_d;
    a_q         <= a_d;
    s_q         <= s_d;
    k_q         <= k_d;
    e_q         <= e_d;
    bidx_q      <= bidx_d;
    verdict_q   <= verdict_d;
    fin_prime_q <= fin_prime_d;
    fin_ovf_q   <= fin_ovf_d;
    is_prime_q  <= is_prime_d;
    prime_q     <= prime_d;
    ovf_q       <= ovf_d;
  end

  assign out_valid_o   = out_valid_q;
  assign is_prime_o    = is_prime_q;
  assign prime_found_o = prime_q;
  assign overflow_o    = ovf_q;

endmodule

>>> design/ptnp_checker.sv
module ptnp_checker #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic                   is_prime_o,
  input logic [VALUE_WIDTH-1:0] prime_found_o,
  input logic                   overflow_o
);

  // a result item waiting for the sink holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(prime_found_o) &&
    $stable(is_prime_o) && $stable(overflow_o))
    else $error("result item changed while stalled");

  // overflow reports zero and no prime
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> !is_prime_o && prime_found_o == '0)
    else $error("overflow item carries a value");

  // a reported prime above two is odd
  a_prime_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_prime_o && prime_found_o > VALUE_WIDTH'(2) |-> prime_found_o[0])
    else $error("even value reported prime");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while busy");

endmodule

bind prime_test_and_next_prime ptnp_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_ptnp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .is_prime_o    (is_prime_o),
  .prime_found_o (prime_found_o),
  .overflow_o    (overflow_o)
);
